@@ sv/seu_pkg.sv @@
`default_nettype none
package seu_pkg;

   localparam int NUM_ESCAPES = 16;
   localparam int ESC_BYTES   = 4;   // longest partial escape that is held
   localparam int PAT_BYTES   = 5;   // longest escape pattern
   localparam int MAX_RESULTS = 6;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_COLON  = 8'h3A;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_end;
      logic       run_last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]                 len;
      logic [PAT_BYTES-1:0][7:0] pat;   // byte 0 is the leading dollar
      logic [7:0]                 ch;
   } esc_entry_type;

   typedef enum logic [1:0] {
      MATCH_NONE,
      MATCH_PREFIX,
      MATCH_FULL
   } match_kind_type;

   typedef struct packed {
      match_kind_type kind;
      logic [7:0]     ch;
   } match_type;

   localparam esc_entry_type ESC_TABLE [NUM_ESCAPES] = '{
      '{3'd4, {8'h00, 8'h24, 8'h50, 8'h53, 8'h24}, 8'h40},  // SP -> @
      '{3'd4, {8'h00, 8'h24, 8'h50, 8'h42, 8'h24}, 8'h2A},  // BP -> *
      '{3'd4, {8'h00, 8'h24, 8'h46, 8'h52, 8'h24}, 8'h26},  // RF -> &
      '{3'd4, {8'h00, 8'h24, 8'h54, 8'h4C, 8'h24}, 8'h3C},  // LT -> <
      '{3'd4, {8'h00, 8'h24, 8'h54, 8'h47, 8'h24}, 8'h3E},  // GT -> >
      '{3'd4, {8'h00, 8'h24, 8'h50, 8'h4C, 8'h24}, 8'h28},  // LP -> (
      '{3'd4, {8'h00, 8'h24, 8'h50, 8'h52, 8'h24}, 8'h29},  // RP -> )
      '{3'd3, {8'h00, 8'h00, 8'h24, 8'h43, 8'h24}, 8'h2C},  // C  -> ,
      '{3'd5, {8'h24, 8'h30, 8'h32, 8'h75, 8'h24}, 8'h20},  // u20 -> space
      '{3'd5, {8'h24, 8'h32, 8'h32, 8'h75, 8'h24}, 8'h22},  // u22 -> "
      '{3'd5, {8'h24, 8'h37, 8'h32, 8'h75, 8'h24}, 8'h27},  // u27 -> '
      '{3'd5, {8'h24, 8'h62, 8'h32, 8'h75, 8'h24}, 8'h2B},  // u2b -> +
      '{3'd5, {8'h24, 8'h62, 8'h33, 8'h75, 8'h24}, 8'h3B},  // u3b -> ;
      '{3'd5, {8'h24, 8'h62, 8'h35, 8'h75, 8'h24}, 8'h5B},  // u5b -> [
      '{3'd5, {8'h24, 8'h64, 8'h35, 8'h75, 8'h24}, 8'h5D},  // u5d -> ]
      '{3'd5, {8'h24, 8'h65, 8'h37, 8'h75, 8'h24}, 8'h7E}   // u7e -> ~
   };

   // Match the held bytes plus one new byte against all escapes in parallel.
   // n is the number of held bytes, 1 to ESC_BYTES.
   function automatic match_type classify(input logic [ESC_BYTES-1:0][7:0] held,
                                          input logic [2:0] n,
                                          input logic [7:0] b);
      logic [PAT_BYTES-1:0][7:0] cand;
      logic                      hit;
      logic [2:0]                clen;
      match_type                 res;
      cand     = {8'h00, held};
      cand[n]  = b;
      clen     = n + 3'd1;
      res.kind = MATCH_NONE;
      res.ch   = 8'h00;
      for (int i = NUM_ESCAPES - 1; i >= 0; i--) begin
         hit = (ESC_TABLE[i].len >= clen);
         for (int k = 0; k < PAT_BYTES; k++) begin
            if (k[2:0] < clen && ESC_TABLE[i].pat[k] != cand[k]) begin
               hit = 1'b0;
            end
         end
         if (hit && ESC_TABLE[i].len == clen) begin
            res.kind = MATCH_FULL;
            res.ch   = ESC_TABLE[i].ch;
         end else if (hit && res.kind != MATCH_FULL) begin
            res.kind = MATCH_PREFIX;
         end
      end
      return res;
   endfunction

endpackage
`default_nettype wire

@@ sv/symbol_escape_unescaper_top.sv @@
// Streaming unescaper for demangled symbol text.
// req channel: one symbol byte per transfer, in_last on the final byte.
// rsp channel: the cleaned text, one byte per transfer. run_last marks the
// last byte caused by an input byte, out_end the final byte of the symbol.
// Dollar escapes ($LT$, $u20$ and the rest) become one character, a dot
// pair becomes "::". A partial escape of up to four bytes or one dot is held
// between bytes; a failed escape is sent out literally.
// Structure: an input register, then one pass of logic that computes all
// results of the byte (0 to 5) into a burst register drained one per cycle
// while rsp_stall is low. A byte passes the input register, then the burst
// register, before its first result can be transferred out.
// Throughput: one byte per cycle while each byte yields at most one result
// and rsp_stall is low; a byte that yields more results holds the next one
// while the single-byte result port drains the burst register.
// Reset clears the held escape and dot and empties both registers; nothing is
// sent until new bytes arrive. When rsp_stall is high the current result
// holds and, once the burst register and input register are full, req_stall
// rises and holds the input side.
`default_nettype none
module symbol_escape_unescaper_top import seu_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic                          in_valid_ff, in_valid_in;
   req_type                       in_data_ff;

   logic [ESC_BYTES-1:0][7:0]     esc_buf_ff, esc_buf_in;
   logic [2:0]                    esc_len_ff, esc_len_in;
   logic                          dot_ff, dot_in;

   logic [MAX_RESULTS-1:0][7:0]   burst_ff, burst_in;
   logic [2:0]                    count_ff, count_in;
   logic                          end_ff, end_in;

   logic [MAX_RESULTS-1:0][7:0]   res_bytes;
   logic [2:0]                    res_cnt;
   logic                          done;
   match_type                     match;

   logic                          rsp_xfer, req_xfer, can_load, proc;

   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_xfer  = rsp_valid && !rsp_stall;
   assign can_load  = (count_ff == 3'd0) || (count_ff == 3'd1 && rsp_xfer);
   assign proc      = in_valid_ff && can_load;
   assign req_stall = in_valid_ff && !can_load;
   assign req_xfer  = req_valid && !req_stall;

   assign rsp_data.out_byte = burst_ff[0];
   assign rsp_data.run_last = (count_ff == 3'd1);
   assign rsp_data.out_end  = end_ff && (count_ff == 3'd1);

   assign match = classify(esc_buf_ff, esc_len_ff, in_data_ff.in_byte);

   // Results of the registered byte and the state it leaves behind.
   always_comb begin
      res_bytes  = '0;
      res_cnt    = 3'd0;
      done       = 1'b0;
      esc_buf_in = esc_buf_ff;
      esc_len_in = esc_len_ff;
      dot_in     = dot_ff;

      if (esc_len_ff != 3'd0) begin
         if (match.kind == MATCH_FULL) begin
            res_bytes[res_cnt] = match.ch;
            res_cnt            = res_cnt + 3'd1;
            esc_buf_in         = '0;
            esc_len_in         = 3'd0;
            done               = 1'b1;
         end else if (match.kind == MATCH_PREFIX && esc_len_ff < 3'(ESC_BYTES)) begin
            esc_buf_in[esc_len_ff[1:0]] = in_data_ff.in_byte;
            esc_len_in                  = esc_len_ff + 3'd1;
            done                        = 1'b1;
         end else begin
            // failed escape: send the held bytes literally
            for (int k = 0; k < ESC_BYTES; k++) begin
               if (k[2:0] < esc_len_ff && res_cnt < 3'(MAX_RESULTS)) begin
                  res_bytes[res_cnt] = esc_buf_ff[k];
                  res_cnt            = res_cnt + 3'd1;
               end
            end
            esc_buf_in = '0;
            esc_len_in = 3'd0;
         end
      end

      if (!done) begin
         if (in_data_ff.in_byte == CH_DOLLAR) begin
            if (dot_in) begin
               res_bytes[res_cnt] = CH_DOT;
               res_cnt            = res_cnt + 3'd1;
               dot_in             = 1'b0;
            end
            esc_buf_in = {{(ESC_BYTES-1){8'h00}}, CH_DOLLAR};
            esc_len_in = 3'd1;
         end else if (in_data_ff.in_byte == CH_DOT) begin
            if (dot_in) begin
               res_bytes[res_cnt] = CH_COLON;
               res_cnt            = res_cnt + 3'd1;
               res_bytes[res_cnt] = CH_COLON;
               res_cnt            = res_cnt + 3'd1;
               dot_in             = 1'b0;
            end else begin
               dot_in = 1'b1;
            end
         end else begin
            if (dot_in) begin
               res_bytes[res_cnt] = CH_DOT;
               res_cnt            = res_cnt + 3'd1;
               dot_in             = 1'b0;
            end
            res_bytes[res_cnt] = in_data_ff.in_byte;
            res_cnt            = res_cnt + 3'd1;
         end
      end

      // end of symbol: flush everything still held
      if (in_data_ff.in_last) begin
         for (int k = 0; k < ESC_BYTES; k++) begin
            if (k[2:0] < esc_len_in && res_cnt < 3'(MAX_RESULTS)) begin
               res_bytes[res_cnt] = esc_buf_in[k];
               res_cnt            = res_cnt + 3'd1;
            end
         end
         if (dot_in && res_cnt < 3'(MAX_RESULTS)) begin
            res_bytes[res_cnt] = CH_DOT;
            res_cnt            = res_cnt + 3'd1;
         end
         esc_buf_in = '0;
         esc_len_in = 3'd0;
         dot_in     = 1'b0;
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (proc) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      burst_in = burst_ff;
      count_in = count_ff;
      end_in   = end_ff;
      if (proc) begin
         burst_in = res_bytes;
         count_in = res_cnt;
         end_in   = in_data_ff.in_last;
      end else if (rsp_xfer) begin
         // advance to the next byte of the burst
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            burst_in[i] = burst_ff[i+1];
         end
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         esc_buf_ff  <= '0;
         esc_len_ff  <= 3'd0;
         dot_ff      <= 1'b0;
         count_ff    <= 3'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         count_ff    <= count_in;
         if (proc) begin
            esc_buf_ff <= esc_buf_in;
            esc_len_ff <= esc_len_in;
            dot_ff     <= dot_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_data_ff <= req_data;
      end
      burst_ff <= burst_in;
      end_ff   <= end_in;
   end

   a_escape_or_dot : assert property (@(posedge clock) disable iff (reset)
      !(esc_len_ff != 3'd0 && dot_ff))
      else $error("escape and dot held at once");

   a_escape_len : assert property (@(posedge clock) disable iff (reset)
      esc_len_ff <= 3'(ESC_BYTES))
      else $error("held escape too long");

   a_last_clears : assert property (@(posedge clock) disable iff (reset)
      proc && in_data_ff.in_last |=> esc_len_ff == 3'd0 && !dot_ff)
      else $error("state not cleared after final byte");

   a_burst_count : assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(MAX_RESULTS))
      else $error("burst count out of range");

endmodule
`default_nettype wire

@@ dv/symbol_escape_unescaper_top_tb.sv @@
module symbol_escape_unescaper_top_tb import seu_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int LONG_HOLD   = 150;

   typedef logic [7:0] byte_q_type[$];

   typedef struct packed {
      logic [39:0] text;   // escape text, right-justified, first char highest
      logic [2:0]  len;
      logic [7:0]  ch;
   } escape_def_type;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   symbol_escape_unescaper_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // predictor state
   logic [3:0][7:0] esc_held;
   int              esc_count;
   logic            dot_held;
   logic [7:0]      burst[$];
   rsp_type         cleaned_bytes_q[$];

   int  error_count = 0;
   int  cycle_count = 0;
   int  bytes_sent  = 0;
   int  req_gap     = 0;
   int  hold_left   = 0;
   bit  gaps_on     = 1'b0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic escape_def_type escape_def(input int idx);
      case (idx)
         0:       return '{"$SP$",  3'd4, "@"};
         1:       return '{"$BP$",  3'd4, "*"};
         2:       return '{"$RF$",  3'd4, "&"};
         3:       return '{"$LT$",  3'd4, "<"};
         4:       return '{"$GT$",  3'd4, ">"};
         5:       return '{"$LP$",  3'd4, "("};
         6:       return '{"$RP$",  3'd4, ")"};
         7:       return '{"$C$",   3'd3, ","};
         8:       return '{"$u20$", 3'd5, " "};
         9:       return '{"$u22$", 3'd5, "\""};
         10:      return '{"$u27$", 3'd5, "'"};
         11:      return '{"$u2b$", 3'd5, "+"};
         12:      return '{"$u3b$", 3'd5, ";"};
         13:      return '{"$u5b$", 3'd5, "["};
         14:      return '{"$u5d$", 3'd5, "]"};
         default: return '{"$u7e$", 3'd5, "~"};
      endcase
   endfunction

   function automatic logic [7:0] escape_char_at(input escape_def_type d, input int k);
      int dl;
      dl = int'(d.len);
      return d.text[8*(dl-1-k) +: 8];
   endfunction

   function automatic match_kind_type match_escape(input logic [4:0][7:0] cand,
                                                   input int n,
                                                   output logic [7:0] ch);
      escape_def_type d;
      match_kind_type kind;
      bit             same;
      kind = MATCH_NONE;
      ch   = 8'h00;
      for (int i = 0; i < NUM_ESCAPES; i++) begin
         d    = escape_def(i);
         same = (int'(d.len) >= n);
         if (same) begin
            for (int k = 0; k < n; k++) begin
               if (escape_char_at(d, k) != cand[k]) same = 1'b0;
            end
         end
         if (same && int'(d.len) == n) begin
            ch = d.ch;
            return MATCH_FULL;
         end
         if (same) kind = MATCH_PREFIX;
      end
      return kind;
   endfunction

   function automatic void spill_escape();
      for (int k = 0; k < esc_count; k++) burst.push_back(esc_held[k]);
      esc_count = 0;
      esc_held  = '0;
   endfunction

   task automatic predict_cleaned(input logic [7:0] b, input logic last);
      logic [4:0][7:0] cand;
      logic [7:0]      ch;
      match_kind_type  kind;
      bit              handled;
      rsp_type         r;
      handled = 1'b0;
      burst.delete();
      if (esc_count > 0) begin
         cand            = '0;
         cand[3:0]       = esc_held;
         cand[esc_count] = b;
         kind = match_escape(cand, esc_count + 1, ch);
         if (kind == MATCH_FULL) begin
            burst.push_back(ch);
            esc_count = 0;
            esc_held  = '0;
            handled   = 1'b1;
         end else if (kind == MATCH_PREFIX && esc_count < ESC_BYTES) begin
            esc_held[esc_count] = b;
            esc_count++;
            handled = 1'b1;
         end else begin
            // failed escape goes out literally, then the byte is taken afresh
            spill_escape();
         end
      end
      if (!handled) begin
         if (b == CH_DOLLAR) begin
            if (dot_held) burst.push_back(CH_DOT);
            dot_held    = 1'b0;
            esc_held    = '0;
            esc_held[0] = b;
            esc_count   = 1;
         end else if (b == CH_DOT) begin
            if (dot_held) begin
               burst.push_back(CH_COLON);
               burst.push_back(CH_COLON);
               dot_held = 1'b0;
            end else begin
               dot_held = 1'b1;
            end
         end else begin
            if (dot_held) burst.push_back(CH_DOT);
            dot_held = 1'b0;
            burst.push_back(b);
         end
      end
      if (last) begin
         spill_escape();
         if (dot_held) burst.push_back(CH_DOT);
         dot_held = 1'b0;
      end
      for (int i = 0; i < burst.size(); i++) begin
         r.out_byte = burst[i];
         r.run_last = (i == burst.size() - 1);
         r.out_end  = last && (i == burst.size() - 1);
         cleaned_bytes_q.push_back(r);
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input logic last);
      if (req_gap > 0) repeat (req_gap) @(posedge clock);
      req_gap = 0;
      req_valid <= 1'b1;
      req_data  <= {b, last};
      do @(posedge clock); while (req_stall);
      predict_cleaned(b, last);
      bytes_sent++;
      // pick the gap before the next byte now, so valid drops only once
      req_gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
      if (req_gap > 0) req_valid <= 1'b0;
   endtask

   task automatic req_quiet();
      if (req_gap == 0) begin
         req_valid <= 1'b0;
         req_gap = 1;
      end
   endtask

   task automatic send_symbol(input byte_q_type sym);
      for (int i = 0; i < sym.size(); i++) send_byte(sym[i], i == sym.size() - 1);
   endtask

   task automatic send_text(input string s);
      byte_q_type q;
      for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
      send_symbol(q);
   endtask

   task automatic build_symbol(output byte_q_type sym);
      escape_def_type d;
      int             cut;
      sym.delete();
      repeat ($urandom_range(1, 6)) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               d = escape_def($urandom_range(0, NUM_ESCAPES - 1));
               for (int k = 0; k < d.len; k++) sym.push_back(escape_char_at(d, k));
            end
            4: begin
               sym.push_back(CH_DOT);
               sym.push_back(CH_DOT);
            end
            5: sym.push_back(CH_DOT);
            6, 7: sym.push_back(8'($urandom_range(1, 255)));
            default: begin
               // cut an escape short and follow it with any nonzero byte
               d   = escape_def($urandom_range(0, NUM_ESCAPES - 1));
               cut = $urandom_range(1, d.len - 1);
               for (int k = 0; k < cut; k++) sym.push_back(escape_char_at(d, k));
               sym.push_back(8'($urandom_range(1, 255)));
            end
         endcase
      end
   endtask

   task automatic send_random_text(input int n_bytes, input bit with_gaps);
      byte_q_type sym;
      int         start;
      start = bytes_sent;
      while (bytes_sent - start < n_bytes) begin
         gaps_on = with_gaps && ($urandom_range(0, 3) != 0);
         build_symbol(sym);
         send_symbol(sym);
      end
   endtask

   task automatic wait_for_drain();
      req_quiet();
      while (cleaned_bytes_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_plain_bytes();
      byte_q_type sym;
      sym = '{8'h01, 8'h80, 8'h7F, 8'hFF};
      send_symbol(sym);
   endtask

   task automatic test_escapes();
      send_text("$C$");
      send_text("$u7e$");
   endtask

   task automatic test_dot_pairs();
      send_text("..");
      send_text(".a");
      send_text(".");
   endtask

   task automatic test_broken_escapes();
      send_text(".$Q");
      send_text("$u2b.");
      send_text("$$");
   endtask

   task automatic test_random_symbols(input int n_bytes, input bit with_gaps);
      send_random_text(n_bytes, with_gaps);
      gaps_on = 1'b0;
   endtask

   task automatic test_receiver_hold();
      // hold the result side long enough for the input side to back up
      gaps_on   = 1'b0;
      hold_left = LONG_HOLD;
      send_random_text(30, 1'b0);
   endtask

   task automatic test_sender_pause();
      wait_for_drain();
      send_random_text(12, 1'b1);
   endtask

   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            hold_left = $urandom_range(1, 18) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : check_cleaned
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (cleaned_bytes_q.size() == 0) begin
            $error("out_byte: expected none, got %h", rsp_data.out_byte);
            error_count++;
         end else begin
            want = cleaned_bytes_q.pop_front();
            if (rsp_data.out_byte !== want.out_byte) begin
               $error("out_byte: expected %h, got %h", want.out_byte, rsp_data.out_byte);
               error_count++;
            end
            if (rsp_data.out_end !== want.out_end) begin
               $error("out_end: expected %b, got %b", want.out_end, rsp_data.out_end);
               error_count++;
            end
            if (rsp_data.run_last !== want.run_last) begin
               $error("run_last: expected %b, got %b", want.run_last, rsp_data.run_last);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      esc_held  = '0;
      esc_count = 0;
      dot_held  = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_plain_bytes();
      test_escapes();
      test_dot_pairs();
      test_broken_escapes();
      wait_for_drain();
      test_random_symbols(100, 1'b1);
      test_receiver_hold();
      test_sender_pause();
      test_random_symbols(40, 1'b0);

      wait_for_drain();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/seu_pkg.sv
sv/symbol_escape_unescaper_top.sv
dv/symbol_escape_unescaper_top_tb.sv
